// ===== hdl/tbg_pkg.sv =====
// ----------------------------------------------------------------------------
// Tone burst generator package
// Shared types and codes for the tone burst generator and its submodules.
// ----------------------------------------------------------------------------
`default_nettype none

package tbg_pkg;

	localparam int unsigned RATE_W   = 28;
	localparam int unsigned HALF_W   = 27;
	localparam int unsigned FREQ_W   = 16;
	localparam int unsigned DUR_W    = 16;
	localparam int unsigned PERMS_W  = 17;
	localparam int unsigned DIVN_W   = 33;
	localparam int unsigned PHASE_W  = 28;
	localparam int unsigned CYCLE_W  = 32;
	localparam int unsigned MS_DIV   = 2000;

	// The rate is divided by MS_DIV through a multiply by its scaled reciprocal,
	// which is exact for every 28-bit rate.
	localparam int unsigned MS_RECIP       = 274877907;
	localparam int unsigned MS_RECIP_SHIFT = 39;
	localparam int unsigned MS_PROD_W      = 57;

	typedef enum logic [0:0] {
		REG_SINGLE_PIN_MODE = 1'b0,
		REG_TICK_RATE       = 1'b1
	} reg_index_t;

	typedef enum logic [0:0] {
		KIND_TICK  = 1'b0,
		KIND_START = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_ZERO_FREQ = 2'd1,
		STAT_BUSY      = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_HALF_GO,
		SEQ_HALF_WAIT,
		SEQ_PER_MS,
		SEQ_MUL,
		SEQ_CNT_GO,
		SEQ_CNT_WAIT
	} seq_state_t;

	typedef struct packed {
		logic tick;
		logic load;
	} tbg_cmd_t;

	typedef struct packed {
		logic active;
		logic high;
	} tbg_phase_t;

endpackage

`default_nettype wire

// ===== hdl/tbg_div.sv =====
// ----------------------------------------------------------------------------
// Tone burst generator divider
// Restoring divider that produces one quotient bit per clock cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tbg_div import tbg_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DIVN_W-1:0] dividend,
	input  wire logic [HALF_W-1:0] divisor,
	output logic                   done,
	output logic [DIVN_W-1:0]      quotient
);

	localparam int unsigned CNT_W = $clog2(DIVN_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [HALF_W-1:0] rem_q;
	logic [HALF_W-1:0] div_q;
	logic [DIVN_W-1:0] quo_q;
	logic [HALF_W:0]   trial;
	logic [HALF_W:0]   diff;
	logic              qbit;

	always_comb begin
		trial = {rem_q, quo_q[DIVN_W-1]};
		diff  = trial - {1'b0, div_q};
		qbit  = (trial >= {1'b0, div_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIVN_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[HALF_W-1:0] : trial[HALF_W-1:0];
			quo_q <= {quo_q[DIVN_W-2:0], qbit};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ===== hdl/tbg_player.sv =====
// ----------------------------------------------------------------------------
// Tone burst generator player
// Phase and cycle counters that play a burst one tick at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module tbg_player import tbg_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire tbg_cmd_t           cmd,
	input  wire logic [HALF_W-1:0]  half,
	input  wire logic [CYCLE_W-1:0] count,
	input  wire logic               single_mode,
	output tbg_phase_t              cur,
	output tbg_phase_t              nxt
);

	logic               active_q, active_d;
	logic               high_q, high_d;
	logic [PHASE_W-1:0] left_q, left_d;
	logic [CYCLE_W-1:0] cycles_q, cycles_d;
	logic [PHASE_W-1:0] first_q, first_d;
	logic [PHASE_W-1:0] second_q, second_d;
	logic [PHASE_W-1:0] half_ext;
	logic [PHASE_W-1:0] quarter;

	always_comb begin
		half_ext = {1'b0, half};
		quarter  = {3'b000, half[HALF_W-1:2]};
		active_d = active_q;
		high_d   = high_q;
		left_d   = left_q;
		cycles_d = cycles_q;
		first_d  = first_q;
		second_d = second_q;
		if (cmd.load) begin
			if (single_mode) begin
				first_d  = quarter;
				second_d = half_ext + (half_ext - quarter);
			end else begin
				first_d  = half_ext;
				second_d = half_ext;
			end
			active_d = 1'b1;
			cycles_d = count;
			if (first_d == '0) begin
				high_d = 1'b0;
				left_d = second_d;
			end else begin
				high_d = 1'b1;
				left_d = first_d;
			end
		end else if (cmd.tick && active_q) begin
			if (left_q > PHASE_W'(1)) begin
				left_d = left_q - 1'b1;
			end else if (high_q) begin
				high_d = 1'b0;
				left_d = second_q;
			end else if (cycles_q != '0) begin
				cycles_d = cycles_q - 1'b1;
				if (first_q == '0) begin
					high_d = 1'b0;
					left_d = second_q;
				end else begin
					high_d = 1'b1;
					left_d = first_q;
				end
			end else begin
				active_d = 1'b0;
				high_d   = 1'b0;
				left_d   = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			high_q   <= 1'b0;
			left_q   <= '0;
			cycles_q <= '0;
			first_q  <= '0;
			second_q <= '0;
		end else begin
			active_q <= active_d;
			high_q   <= high_d;
			left_q   <= left_d;
			cycles_q <= cycles_d;
			first_q  <= first_d;
			second_q <= second_d;
		end
	end

	assign cur.active = active_q;
	assign cur.high   = high_q;
	assign nxt.active = active_d;
	assign nxt.high   = high_d;

endmodule

`default_nettype wire

// ===== hdl/tone_burst_generator_top.sv =====
// ----------------------------------------------------------------------------
// Tone burst generator
// Square-wave tone bursts on one or two pins, timed by incoming tick words.
// ----------------------------------------------------------------------------
// A tick word is taken every clock cycle unless the input stalls; its result
// word comes from the output register in the next cycle. A start word runs
// two divisions on a shared bit-serial divider (one quotient bit per cycle
// over 33 bits), a reciprocal multiply for the ticks per millisecond and a
// multiply for the tick count in states HALF_GO to CNT_WAIT, with the input
// stalled until its result is registered. Refused start words return at once.
`default_nettype none

module tone_burst_generator_top import tbg_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [RATE_W-1:0] cfg_data,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              kind,
	input  wire logic [FREQ_W-1:0] freq_hz,
	input  wire logic [DUR_W-1:0]  duration_ms,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   pin_a,
	output logic                   pin_b,
	output logic                   busy_res,
	output logic [1:0]             status
);

	seq_state_t          state_q, state_d;
	logic                mode_q;
	logic [RATE_W-1:0]   rate_q;
	logic [FREQ_W-1:0]   freq_q;
	logic [DUR_W-1:0]    dur_q;
	logic [HALF_W-1:0]   half_q;
	logic [PERMS_W-1:0]  per_ms_q;
	logic [DIVN_W-1:0]   prod_q;
	logic                out_valid_q;
	logic                pin_a_q;
	logic                pin_b_q;
	logic                busy_q;
	status_t             status_q;

	logic                accept;
	logic                is_start;
	logic                refuse;
	logic                go;
	logic                div_start;
	logic                div_done;
	logic [DIVN_W-1:0]   div_dividend;
	logic [HALF_W-1:0]   div_divisor;
	logic [DIVN_W-1:0]   div_quo;
	logic [CYCLE_W-1:0]  count_sat;
	logic [MS_PROD_W-1:0] per_ms_prod;
	tbg_cmd_t            cmd;
	tbg_phase_t          cur;
	tbg_phase_t          nxt;

	assign in_stall = (state_q != SEQ_IDLE) || (out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;
	assign is_start = (kind_t'(kind) == KIND_START);
	assign refuse   = accept && is_start && ((freq_hz == '0) || cur.active);
	assign go       = accept && is_start && (freq_hz != '0) && !cur.active;
	assign count_sat = div_quo[DIVN_W-1] ? '1 : div_quo[CYCLE_W-1:0];
	assign per_ms_prod = MS_PROD_W'(rate_q) * MS_PROD_W'(MS_RECIP);

	always_comb begin
		state_d = state_q;
		case (state_q)
			SEQ_IDLE:      if (go) state_d = SEQ_HALF_GO;
			SEQ_HALF_GO:   state_d = SEQ_HALF_WAIT;
			SEQ_HALF_WAIT: if (div_done) state_d = SEQ_PER_MS;
			SEQ_PER_MS:    state_d = SEQ_MUL;
			SEQ_MUL:       state_d = SEQ_CNT_GO;
			SEQ_CNT_GO:    state_d = SEQ_CNT_WAIT;
			SEQ_CNT_WAIT:  if (div_done) state_d = SEQ_IDLE;
			default:       state_d = SEQ_IDLE;
		endcase
	end

	always_comb begin
		div_start    = 1'b0;
		div_dividend = prod_q;
		div_divisor  = half_q;
		cmd.tick     = accept && !is_start;
		cmd.load     = 1'b0;
		case (state_q)
			SEQ_HALF_GO: begin
				div_start    = 1'b1;
				div_dividend = DIVN_W'(rate_q[RATE_W-1:1]);
				div_divisor  = HALF_W'(freq_q);
			end
			SEQ_CNT_GO: begin
				div_start = 1'b1;
			end
			SEQ_CNT_WAIT: begin
				cmd.load = div_done;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
			mode_q  <= 1'b1;
			rate_q  <= RATE_W'(80000000);
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (reg_index_t'(cfg_index))
					REG_SINGLE_PIN_MODE: mode_q <= cfg_data[0];
					REG_TICK_RATE:       rate_q <= cfg_data;
					default:             mode_q <= mode_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			freq_q <= freq_hz;
			dur_q  <= duration_ms;
		end
		if (state_q == SEQ_HALF_WAIT && div_done) begin
			half_q <= (div_quo[HALF_W-1:0] == '0) ? HALF_W'(1) : div_quo[HALF_W-1:0];
		end
		if (state_q == SEQ_PER_MS) begin
			per_ms_q <= per_ms_prod[MS_RECIP_SHIFT +: PERMS_W];
		end
		if (state_q == SEQ_MUL) begin
			prod_q <= DIVN_W'(dur_q) * DIVN_W'(per_ms_q);
		end
	end

	tbg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	tbg_player u_player (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.half        (half_q),
		.count       (count_sat),
		.single_mode (mode_q),
		.cur         (cur),
		.nxt         (nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.tick || cmd.load || refuse) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tick || cmd.load) begin
			pin_a_q  <= nxt.active && nxt.high;
			pin_b_q  <= nxt.active && !nxt.high && !mode_q;
			busy_q   <= nxt.active;
			status_q <= STAT_OK;
		end else if (refuse) begin
			pin_a_q  <= cur.active && cur.high;
			pin_b_q  <= cur.active && !cur.high && !mode_q;
			busy_q   <= cur.active;
			status_q <= (freq_hz == '0) ? STAT_ZERO_FREQ : STAT_BUSY;
		end
	end

	assign out_valid = out_valid_q;
	assign pin_a     = pin_a_q;
	assign pin_b     = pin_b_q;
	assign busy_res  = busy_q;
	assign status    = status_q;

`ifndef SYNTHESIS
	a_load_starts_burst: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cur.active)
		else $error("Burst not active after a completed start.");

	a_idle_pins_low: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !busy_q) |-> (!pin_a_q && !pin_b_q))
		else $error("Pins driven while no burst is playing.");

	a_div_done_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == SEQ_HALF_WAIT || state_q == SEQ_CNT_WAIT))
		else $error("Divider finished outside a wait state.");

	a_no_tick_while_computing: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != SEQ_IDLE) |-> !cmd.tick)
		else $error("Tick applied during start computation.");
`endif

endmodule

`default_nettype wire
